// ----- hdl/adsr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared widths, constants, codes and controller/datapath handshake types
// for the linear ADSR envelope with a steal phase.
// ----------------------------------------------------------------------------
package adsr_pkg;

    // field widths
    localparam int OP_W      = 2;
    localparam int FRAMES_W  = 13;
    localparam int PHASE_W   = 3;
    localparam int LEVEL_W   = 25;
    localparam int STEP_W    = 26;
    localparam int REG_IDX_W = 3;

    // default block length limit
    localparam int MAX_BLOCK_DEF = 4096;

    // level constants, Q1.24
    localparam logic [LEVEL_W-1:0] ONE_Q24      = 25'd16777216;
    localparam logic [LEVEL_W-1:0] SUSTAIN_SKIP = 25'd16760439;
    localparam logic [LEVEL_W-1:0] IDLE_FLOOR   = 25'd1677;

    // event codes
    typedef enum logic [OP_W-1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_STEAL    = 2'd2,
        OP_ADVANCE  = 2'd3
    } op_t;

    // envelope phases
    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4,
        PH_STEAL   = 3'd5
    } phase_t;

    // register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_ATTACK_STEP   = 3'd0,
        REG_DECAY_STEP    = 3'd1,
        REG_SUSTAIN_LEVEL = 3'd2,
        REG_RELEASE_STEP  = 3'd3,
        REG_STEAL_STEP    = 3'd4
    } reg_idx_t;

    // controller states
    typedef enum logic [2:0] {
        ST_WAIT,
        ST_MUL,
        ST_EVAL,
        ST_DIV_START,
        ST_DIV,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic eval;
        logic div_start;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// ----- hdl/adsr_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_in_if
// Event channel: one beat carries an operation code and a frame count.
// ----------------------------------------------------------------------------
interface adsr_in_if
    import adsr_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [FRAMES_W-1:0] frames;

    modport source (output valid, output operation, output frames, input ready);
    modport sink   (input valid, input operation, input frames, output ready);
endinterface
`default_nettype wire

// ----- hdl/adsr_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_out_if
// Result channel: one beat carries phase, start/end levels and the step.
// ----------------------------------------------------------------------------
interface adsr_out_if
    import adsr_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [PHASE_W-1:0]       phase;
    logic [LEVEL_W-1:0]       level_start;
    logic [LEVEL_W-1:0]       level_end;
    logic signed [STEP_W-1:0] level_step;

    modport source (output valid, output phase, output level_start,
                    output level_end, output level_step, input ready);
    modport sink   (input valid, input phase, input level_start,
                    input level_end, input level_step, output ready);
endinterface
`default_nettype wire

// ----- hdl/adsr_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module adsr_div
    import adsr_pkg::*;
#(
    parameter int DVD_W = LEVEL_W,
    parameter int DVS_W = FRAMES_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic      [DVD_W-1:0] quotient,
    output logic                  done
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    // one trial subtraction
    always_comb
    begin
        trial = {rem_reg, acc_reg[DVD_W-1]};
        diff  = trial - {1'b0, divisor};
        fits  = trial >= {1'b0, divisor};
    end

    // iteration control
    always_comb
    begin
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            acc_next  = dividend;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            acc_next = {acc_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        acc_reg <= acc_next;
    end

    assign quotient = acc_reg;
    assign done     = done_reg;
endmodule
`default_nettype wire

// ----- hdl/adsr_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_datapath
// Envelope state, configuration registers, rate multiply, phase update,
// step division and the result register.
// ----------------------------------------------------------------------------
module adsr_datapath
    import adsr_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire dp_cmd_t                  cmd,
    output dp_stat_t                      stat,
    input  wire logic                     wr_en,
    input  wire logic [REG_IDX_W-1:0]     wr_index,
    input  wire logic [LEVEL_W-1:0]       wr_data,
    input  wire logic [OP_W-1:0]          operation,
    input  wire logic [FRAMES_W-1:0]      frames,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [PHASE_W-1:0]            out_phase,
    output logic [LEVEL_W-1:0]            out_level_start,
    output logic [LEVEL_W-1:0]            out_level_end,
    output logic signed [STEP_W-1:0]      out_level_step
);
    localparam int PROD_W = LEVEL_W + FRAMES_W;
    localparam int SUM_W  = PROD_W + 1;

    // configuration
    logic [LEVEL_W-1:0] attack_reg, decay_reg, sustain_reg, release_reg, steal_reg;

    // envelope state
    phase_t             phase_reg, phase_next;
    logic [LEVEL_W-1:0] level_reg, level_next;

    // item in work
    op_t                op_reg;
    logic [FRAMES_W-1:0] n_reg, n_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [LEVEL_W-1:0] start_reg;
    logic [LEVEL_W-1:0] end_reg, end_next;
    logic [LEVEL_W-1:0] mag_reg;
    logic               neg_reg;
    logic               step_en_reg, step_en_next;

    // result register
    logic                     out_valid_reg;
    logic [PHASE_W-1:0]       out_phase_reg;
    logic [LEVEL_W-1:0]       out_start_reg, out_end_reg;
    logic signed [STEP_W-1:0] out_step_reg, step_val;

    logic [LEVEL_W-1:0] sus;
    logic [LEVEL_W-1:0] rate;
    phase_t             ph_norm;
    logic [SUM_W-1:0]   up_sum, floor_sum;
    logic               prod_ge_start;
    logic [LEVEL_W-1:0] down;
    logic               adv;
    logic [STEP_W-1:0]  diff;
    logic [STEP_W-1:0]  diff_abs;
    logic [LEVEL_W-1:0] quotient;
    logic [STEP_W-1:0]  q_ext;
    logic               div_done;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= ONE_Q24;
            decay_reg   <= ONE_Q24;
            sustain_reg <= ONE_Q24;
            release_reg <= ONE_Q24;
            steal_reg   <= ONE_Q24;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_ATTACK_STEP:   attack_reg  <= wr_data;
                REG_DECAY_STEP:    decay_reg   <= wr_data;
                REG_SUSTAIN_LEVEL: sustain_reg <= wr_data;
                REG_RELEASE_STEP:  release_reg <= wr_data;
                REG_STEAL_STEP:    steal_reg   <= wr_data;
                default:           ;
            endcase
        end
    end

    // frame count saturation, sustain clamp and phase normalisation
    always_comb
    begin
        if (32'(frames) > 32'(MAX_BLOCK))
            n_next = FRAMES_W'(MAX_BLOCK);
        else
            n_next = frames;
        sus = (sustain_reg > ONE_Q24) ? ONE_Q24 : sustain_reg;
        ph_norm = (phase_reg > PH_STEAL) ? PH_IDLE : phase_reg;
    end

    // per-sample rate of the current phase
    always_comb
    begin
        case (ph_norm)
            PH_ATTACK:  rate = attack_reg;
            PH_DECAY:   rate = decay_reg;
            PH_RELEASE: rate = release_reg;
            PH_STEAL:   rate = steal_reg;
            default:    rate = '0;
        endcase
    end

    // ramp arithmetic
    always_comb
    begin
        up_sum        = SUM_W'(level_reg) + SUM_W'(prod_reg);
        floor_sum     = SUM_W'(sus) + SUM_W'(prod_reg);
        prod_ge_start = prod_reg >= PROD_W'(level_reg);
        down          = level_reg - prod_reg[LEVEL_W-1:0];
    end

    // phase and level update
    always_comb
    begin
        phase_next = ph_norm;
        end_next   = level_reg;
        adv        = 1'b0;
        unique case (op_reg)
            OP_NOTE_ON:
                phase_next = PH_ATTACK;
            OP_NOTE_OFF:
                if (ph_norm == PH_ATTACK || ph_norm == PH_DECAY || ph_norm == PH_SUSTAIN)
                    phase_next = PH_RELEASE;
            OP_STEAL:
                if (ph_norm != PH_IDLE)
                    phase_next = PH_STEAL;
            default:
            begin
                adv = (ph_norm != PH_IDLE);
                case (ph_norm)
                    PH_ATTACK:
                        if (up_sum >= SUM_W'(ONE_Q24))
                        begin
                            end_next   = ONE_Q24;
                            phase_next = (sus >= SUSTAIN_SKIP) ? PH_SUSTAIN : PH_DECAY;
                        end
                        else
                            end_next = up_sum[LEVEL_W-1:0];
                    PH_DECAY:
                        if (floor_sum >= SUM_W'(level_reg))
                        begin
                            end_next   = sus;
                            phase_next = PH_SUSTAIN;
                        end
                        else
                            end_next = down;
                    PH_SUSTAIN:
                        end_next = sus;
                    PH_RELEASE, PH_STEAL:
                        end_next = prod_ge_start ? '0 : down;
                    default:
                        end_next = level_reg;
                endcase
            end
        endcase
        level_next = end_next;
        // release or steal that falls to the floor goes idle
        if (adv && (phase_next == PH_RELEASE || phase_next == PH_STEAL)
            && end_next <= IDLE_FLOOR)
        begin
            phase_next = PH_IDLE;
            level_next = '0;
        end
        step_en_next = adv && (n_reg > FRAMES_W'(1));
        diff         = STEP_W'(end_next) - STEP_W'(level_reg);
        diff_abs     = diff[STEP_W-1] ? (~diff + STEP_W'(1)) : diff;
    end

    // envelope state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            level_reg <= '0;
        end
        else if (cmd.eval)
        begin
            phase_reg <= phase_next;
            level_reg <= level_next;
        end
    end

    // item pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op_t'(operation);
            n_reg  <= n_next;
        end
        if (cmd.mul)
            prod_reg <= PROD_W'(rate) * PROD_W'(n_reg);
        if (cmd.eval)
        begin
            start_reg   <= level_reg;
            end_reg     <= end_next;
            mag_reg     <= diff_abs[LEVEL_W-1:0];
            neg_reg     <= diff[STEP_W-1];
            step_en_reg <= step_en_next;
        end
    end

    // step division
    adsr_div #(
        .DVD_W(LEVEL_W),
        .DVS_W(FRAMES_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (mag_reg),
        .divisor  (n_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // signed step, zero unless an advance ramp spans more than one sample
    always_comb
    begin
        q_ext = STEP_W'(quotient);
        if (!step_en_reg)
            step_val = '0;
        else if (neg_reg)
            step_val = signed'(~q_ext + STEP_W'(1));
        else
            step_val = signed'(q_ext);
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_phase_reg <= phase_reg;
            out_start_reg <= start_reg;
            out_end_reg   <= end_reg;
            out_step_reg  <= step_val;
        end
    end

    assign stat            = '{div_done: div_done, out_free: (!out_valid_reg || out_ready)};
    assign out_valid       = out_valid_reg;
    assign out_phase       = out_phase_reg;
    assign out_level_start = out_start_reg;
    assign out_level_end   = out_end_reg;
    assign out_level_step  = out_step_reg;
endmodule
`default_nettype wire

// ----- hdl/adsr_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_ctrl
// Sequencer: accept an event, multiply, update, divide, then hand the
// result to the output register.
// ----------------------------------------------------------------------------
module adsr_ctrl
    import adsr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output dp_cmd_t       cmd,
    input  wire dp_stat_t stat
);
    state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_WAIT:      if (in_valid) state_next = ST_MUL;
            ST_MUL:       state_next = ST_EVAL;
            ST_EVAL:      state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV;
            ST_DIV:       if (stat.div_done) state_next = ST_OUT;
            ST_OUT:       if (stat.out_free) state_next = ST_WAIT;
            default:      state_next = ST_WAIT;
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_WAIT:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MUL:       cmd.mul       = 1'b1;
            ST_EVAL:      cmd.eval      = 1'b1;
            ST_DIV_START: cmd.div_start = 1'b1;
            ST_DIV:       ;
            ST_OUT:       cmd.out_load  = stat.out_free;
            default:      ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_WAIT;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

// ----- hdl/adsr_envelope_with_steal.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_envelope_with_steal
// Linear ADSR envelope with a steal phase, Q1.24 level, one result per event.
// ----------------------------------------------------------------------------
// Each event beat on request gives one result beat on result. Events are
// handled one at a time: an accepted beat passes through the accept, the
// rate multiply, the phase update, the divider start, the one-bit-per-cycle
// divider that forms the per-sample step, and the output load, which waits
// for a free result register, before the next beat can be accepted. The
// result register holds a finished beat, so a new event is taken while the
// previous result still waits. Configuration writes go straight to the
// registers and must only be issued while no event is in work. Frame counts
// above MAX_BLOCK are treated as MAX_BLOCK.
module adsr_envelope_with_steal
    import adsr_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    adsr_in_if.sink                   request,
    adsr_out_if.source                result,
    input  wire logic                 wr_en,
    input  wire logic [REG_IDX_W-1:0] wr_index,
    input  wire logic [LEVEL_W-1:0]   wr_data
);
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_ready;

    // sequencer
    adsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    assign request.ready = in_ready;

    // envelope datapath
    adsr_datapath #(
        .MAX_BLOCK(MAX_BLOCK)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .operation       (request.operation),
        .frames          (request.frames),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .out_phase       (result.phase),
        .out_level_start (result.level_start),
        .out_level_end   (result.level_end),
        .out_level_step  (result.level_step)
    );
endmodule
`default_nettype wire

// ----- hdl/adsr_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_checker
// Port-level checks of the envelope block, bound to the top level.
// ----------------------------------------------------------------------------
module adsr_checker
    import adsr_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     req_valid,
    input wire logic                     req_ready,
    input wire logic                     res_valid,
    input wire logic                     res_ready,
    input wire logic [LEVEL_W-1:0]       level_start,
    input wire logic [LEVEL_W-1:0]       level_end,
    input wire logic signed [STEP_W-1:0] level_step
);
    // a stalled result beat stays
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat dropped while stalled");

    // one event in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("event accepted while another is in work");

    // levels never pass full scale
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (level_start <= ONE_Q24) && (level_end <= ONE_Q24))
        else $error("level above full scale");

    // flat ramp has no step
    a_flat_step: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (level_end == level_start) |-> level_step == '0)
        else $error("nonzero step on flat ramp");

    // rising ramp has no negative step
    a_step_sign: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (level_end > level_start) |-> !level_step[STEP_W-1])
        else $error("negative step on rising ramp");
endmodule

bind adsr_envelope_with_steal adsr_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (request.valid),
    .req_ready   (request.ready),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .level_start (result.level_start),
    .level_end   (result.level_end),
    .level_step  (result.level_step)
);
`default_nettype wire
